[rtl/bba_pkg.sv]
// Package for the bitmap block allocator: widths, request kinds, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package bba_pkg;
   localparam int MapDepth    = 4096;
   localparam int SearchLimit = 256;
   localparam int IdxW        = $clog2(MapDepth);
   localparam int CntW        = IdxW + 1;

   typedef enum logic [2:0] {
      KIND_ALLOC = 3'd0, KIND_FREE = 3'd1, KIND_WVALID = 3'd2,
      KIND_QUERY = 3'd3, KIND_INIT = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_PROBE, S_WAIT, S_ACCESS, S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic probe;
      logic access;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic search_go;
      logic probe_end;
   } stat_type;
endpackage
`default_nettype wire

[rtl/bba_ctrl.sv]
// Controller state machine of the bitmap block allocator.
// Depends on bba_pkg; drives the datapath through cmd_type, reads stat_type.
`default_nettype none
module bba_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_fire,
   input  wire logic [2:0]      req_kind,
   input  wire logic            rsp_fire,
   input  wire bba_pkg::stat_type stat,
   output bba_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_ok
);
   import bba_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_INIT)       state_in = S_INIT;
               else if (req_kind == KIND_ALLOC) state_in = S_WAIT;
               else                             state_in = S_ACCESS;
            end
         end
         S_INIT:   if (stat.init_done) state_in = S_ACCESS;
         S_WAIT:   state_in = stat.search_go ? S_PROBE : S_ACCESS;
         S_PROBE:  if (stat.probe_end) state_in = S_ACCESS;
         S_ACCESS: state_in = S_DONE;
         S_DONE:   if (rsp_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load   = (state_ff == S_IDLE) && req_fire;
      cmd.clear  = (state_ff == S_INIT);
      cmd.probe  = (state_ff == S_PROBE);
      cmd.access = (state_ff == S_ACCESS);
      busy   = (state_ff != S_IDLE);
      rsp_ok = (state_ff == S_DONE);
   end
endmodule
`default_nettype wire

[rtl/bba_datapath.sv]
// Datapath of the bitmap block allocator: bitmap memory, counters, cursor,
// probe sequencer and result register. Depends on bba_pkg.
`default_nettype none
module bba_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bba_pkg::cmd_type       cmd,
   input  wire logic [2:0]             in_kind,
   input  wire logic [bba_pkg::IdxW-1:0] in_index,
   input  wire logic                   in_flag,
   input  wire logic [bba_pkg::CntW-1:0] in_count,
   output bba_pkg::stat_type           stat,
   output logic [bba_pkg::IdxW-1:0]    out_index,
   output logic [1:0]                  out_status,
   output logic                        out_used,
   output logic                        out_valid,
   output logic [bba_pkg::CntW-1:0]    out_free,
   output logic [bba_pkg::CntW-1:0]    out_len
);
   import bba_pkg::*;

   // Each entry holds {valid, used}. Initialize clears the entries below the
   // new map length; an entry past the map length is written by an append
   // before it is ever read.
   logic [1:0] mem [MapDepth];
   logic [CntW-1:0] len_ff, free_ff;
   logic [IdxW-1:0] cur_ff, pos_ff, last_ff, idx_ff, res_ff, clr_ff;
   logic [2:0]  kind_ff;
   logic        flag_ff, hit_ff, rd_val_ff, pend_ff;
   logic [CntW:0] probes_ff;
   logic [1:0]  st_ff;
   logic        used_o_ff, valid_o_ff;
   logic [1:0]  rd_ff;
   logic [IdxW-1:0] rd_addr, res_in, alloc_addr;
   logic [1:0]  st_in;
   logic        used_o_in, valid_o_in;
   logic        rd_used, rd_valid, in_range, alloc_wr;
   logic [CntW:0] limit;

   assign rd_used  = rd_ff[0];
   assign rd_valid = rd_ff[1];
   assign limit = (len_ff < CntW'(SearchLimit)) ? {1'b0, len_ff} : (CntW+1)'(SearchLimit);
   assign rd_addr = cmd.load ? in_index : pos_ff;
   assign in_range = {1'b0, idx_ff} < len_ff;
   assign alloc_wr = hit_ff || !len_ff[IdxW];
   assign alloc_addr = hit_ff ? last_ff : len_ff[IdxW-1:0];

   always_ff @(posedge clock) rd_ff <= mem[rd_addr];

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if ({1'b0, clr_ff} < len_ff) mem[clr_ff] <= 2'b00;
      end else if (cmd.access && kind_ff == KIND_ALLOC && alloc_wr) begin
         mem[alloc_addr] <= {(hit_ff ? rd_valid : 1'b0), 1'b1};
      end else if (cmd.access && in_range &&
                   (kind_ff == KIND_FREE || kind_ff == KIND_WVALID)) begin
         mem[idx_ff] <= {(kind_ff == KIND_WVALID) ? flag_ff : rd_valid,
                         (kind_ff == KIND_FREE) ? 1'b0 : rd_used};
      end
   end

   assign stat.init_done = ({1'b0, clr_ff} + 1'b1 >= len_ff);
   assign stat.search_go = (free_ff != '0) && (len_ff != '0);
   assign stat.probe_end = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; free_ff <= '0; cur_ff <= '0; clr_ff <= '0;
      end else begin
         if (cmd.load) begin
            clr_ff <= '0;
         end else if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load && in_kind == KIND_INIT) begin
            len_ff  <= (in_count > CntW'(MapDepth)) ? CntW'(MapDepth) : in_count;
            free_ff <= (in_count > CntW'(MapDepth)) ? CntW'(MapDepth) : in_count;
            cur_ff  <= '0;
         end
         if (cmd.probe && pend_ff) begin
            cur_ff <= ({1'b0, last_ff} + 1'b1 >= len_ff) ? '0 : last_ff + 1'b1;
         end
         if (cmd.access && kind_ff == KIND_ALLOC) begin
            if (hit_ff) free_ff <= free_ff - 1'b1;
            else if (!len_ff[IdxW]) len_ff <= len_ff + 1'b1;
         end
         if (cmd.access && kind_ff == KIND_FREE && in_range && rd_used)
            free_ff <= free_ff + 1'b1;
      end
   end

   // Probe sequencer: one address issued per cycle, data checked next cycle.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind; idx_ff <= in_index; flag_ff <= in_flag;
         hit_ff <= 1'b0; pend_ff <= 1'b0; rd_val_ff <= 1'b0;
         pos_ff <= ({1'b0, cur_ff} < len_ff) ? cur_ff : '0;
         probes_ff <= '0;
      end else if (cmd.probe && !pend_ff) begin
         if (rd_val_ff && !rd_used) begin
            hit_ff <= 1'b1; pend_ff <= 1'b1; pos_ff <= last_ff;
         end else if (probes_ff == limit) begin
            pend_ff <= 1'b1;
         end else begin
            last_ff <= pos_ff;
            rd_val_ff <= 1'b1;
            probes_ff <= probes_ff + 1'b1;
            pos_ff <= ({1'b0, pos_ff} + 1'b1 >= len_ff) ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      res_in     = idx_ff;
      st_in      = ST_OK;
      used_o_in  = 1'b0;
      valid_o_in = 1'b0;
      case (kind_ff)
         KIND_ALLOC: begin
            if (hit_ff) begin
               res_in = last_ff; used_o_in = 1'b1; valid_o_in = rd_valid;
            end else if (!len_ff[IdxW]) begin
               res_in = len_ff[IdxW-1:0]; used_o_in = 1'b1;
            end else begin
               res_in = '0; st_in = ST_FULL;
            end
         end
         KIND_INIT: res_in = idx_ff;
         default: begin
            if (!in_range) st_in = ST_RANGE;
            else begin
               used_o_in  = (kind_ff == KIND_FREE) ? 1'b0 : rd_used;
               valid_o_in = (kind_ff == KIND_WVALID) ? flag_ff : rd_valid;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         res_ff     <= res_in;
         st_ff      <= st_in;
         used_o_ff  <= used_o_in;
         valid_o_ff <= valid_o_in;
      end
   end

   assign out_index  = res_ff;
   assign out_status = st_ff;
   assign out_used   = used_o_ff;
   assign out_valid  = valid_o_ff;
   assign out_free   = free_ff;
   assign out_len    = len_ff;

`ifndef ASSERT_OFF
   a_free_le_len: assert property (@(posedge clock) disable iff (reset)
      free_ff <= len_ff) else $error("free count exceeds map length");
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CntW'(MapDepth)) else $error("map length beyond depth");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |-> probes_ff <= limit) else $error("too many probes");
`endif
endmodule
`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// Top level of the bitmap block allocator: stream ports, controller and datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
`default_nettype none
// One request is handled at a time and its response is held until taken.
// Free, write-valid, query and unknown kinds go straight to the access step;
// an allocate first checks whether a search is needed, and one that searches
// reads one block per cycle, stopping at the first free block or after
// min(map length, 256) probes. Initialize clears the bitmap entries below the
// new map length one per cycle before its access step. The next request can
// be accepted in the cycle after the one in which the response is taken.
module bitmap_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: kind[2:0], block_index[14:3], flag_value[15], block_count[28:16]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: result_index[11:0], status[13:12], used_flag[14], valid_flag[15],
   // free_count[28:16], map_length[41:29]
   output logic [47:0]      rsp_tdata
);
   import bba_pkg::*;
   cmd_type  cmd;
   stat_type stat;
   logic busy, req_fire, rsp_fire;
   logic [IdxW-1:0] o_idx;
   logic [1:0] o_st;
   logic o_u, o_v;
   logic [CntW-1:0] o_f, o_l;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   bba_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_kind(req_tdata[2:0]), .rsp_fire,
      .stat, .cmd, .busy, .rsp_ok(rsp_tvalid)
   );

   bba_datapath u_dp (
      .clock, .reset, .cmd,
      .in_kind(req_tdata[2:0]), .in_index(req_tdata[14:3]),
      .in_flag(req_tdata[15]), .in_count(req_tdata[28:16]),
      .stat, .out_index(o_idx), .out_status(o_st), .out_used(o_u),
      .out_valid(o_v), .out_free(o_f), .out_len(o_l)
   );

   assign rsp_tdata = {6'd0, o_l, o_f, o_v, o_u, o_st, o_idx};
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for bitmap_block_allocator: drives random and directed requests
// on the request stream and checks every response against an internal model.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
`timescale 1ns / 100ps
module tb;
   import bba_pkg::*;

   typedef struct packed {
      logic [12:0] length;
      logic [12:0] free_cnt;
      logic        valid;
      logic        used;
      logic [1:0]  status;
      logic [11:0] index;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   bitmap_block_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   logic        used_bits[MapDepth];
   logic        valid_bits[MapDepth];
   int unsigned length_m, free_m, cursor_m;

   logic [31:0] pending_reqs[$];
   rsp_type     expected_rsps[$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;
   int          send_gap = 0, recv_gap = 0, hold_left = 0;
   bit          hold_req = 1'b0;
   bit          req_tready_q;

   function automatic logic [31:0] pack_req(kind_type k, int idx, bit f, int cnt);
      return {3'b0, cnt[12:0], f, idx[11:0], k};
   endfunction

   function automatic rsp_type mk(int idx, status_type st, bit u, bit v);
      rsp_type r;
      r.index = idx[11:0]; r.status = st; r.used = u; r.valid = v;
      r.free_cnt = free_m[12:0]; r.length = length_m[12:0];
      return r;
   endfunction

   function automatic rsp_type allocate_block();
      int unsigned pos, probes, last, found;
      bit hit;
      hit = 0; found = 0;
      if (free_m > 0 && length_m > 0) begin
         pos = (cursor_m < length_m) ? cursor_m : 0;
         probes = (length_m < SearchLimit) ? length_m : SearchLimit;
         last = pos;
         for (int n = 0; n < probes; n++) begin
            last = pos;
            if (!used_bits[pos]) begin
               hit = 1; found = pos; break;
            end
            pos++;
            if (pos >= length_m) pos = 0;
         end
         cursor_m = last + 1;
         if (cursor_m >= length_m) cursor_m = 0;
      end
      if (hit) begin
         used_bits[found] = 1; free_m--;
         return mk(found, ST_OK, 1, valid_bits[found]);
      end
      if (length_m < MapDepth) begin
         used_bits[length_m] = 1; valid_bits[length_m] = 0;
         length_m++;
         return mk(length_m - 1, ST_OK, 1, 0);
      end
      return mk(0, ST_FULL, 0, 0);
   endfunction

   function automatic rsp_type predict_rsp(logic [31:0] d);
      logic [2:0] k;
      int unsigned idx, cnt;
      k = d[2:0]; idx = d[14:3]; cnt = d[28:16];
      if (k == KIND_ALLOC) return allocate_block();
      if (k == KIND_INIT) begin
         for (int i = 0; i < MapDepth; i++) begin
            used_bits[i] = 0; valid_bits[i] = 0;
         end
         if (cnt > MapDepth) cnt = MapDepth;
         length_m = cnt; free_m = cnt; cursor_m = 0;
         return mk(idx, ST_OK, 0, 0);
      end
      if (idx >= length_m) return mk(idx, ST_RANGE, 0, 0);
      if (k == KIND_FREE) begin
         if (used_bits[idx]) begin
            used_bits[idx] = 0; free_m++;
         end
      end else if (k == KIND_WVALID) begin
         valid_bits[idx] = d[15];
      end
      return mk(idx, ST_OK, used_bits[idx], valid_bits[idx]);
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_q) begin
            if (pending_reqs.size() > 0 && send_gap == 0) begin
               req_tdata <= pending_reqs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_reqs.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin
      req_tready_q <= req_tready;
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(predict_rsp(req_tdata));
         if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 19);
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[41:0];
         if (expected_rsps.size() == 0) begin
            report("unexpected response", got.index, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.index !== want.index) report("result_index", got.index, want.index);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.used !== want.used) report("used_flag", got.used, want.used);
            if (got.valid !== want.valid) report("valid_flag", got.valid, want.valid);
            if (got.free_cnt !== want.free_cnt)
               report("free_count", got.free_cnt, want.free_cnt);
            if (got.length !== want.length) report("map_length", got.length, want.length);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req || hold_left > 0) begin
         rsp_tready <= 1'b0;
         if (hold_req) begin
            hold_left = 300; hold_req = 0;
         end else hold_left--;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 19);
      end
   end

   always @(posedge clock) begin
      if (cycles > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add(kind_type k, int idx, bit f, int cnt);
      pending_reqs.push_back(pack_req(k, idx, f, cnt));
   endtask

   task automatic add_raw(logic [31:0] d);
      pending_reqs.push_back(d);
   endtask

   initial begin
      int r;
      for (int i = 0; i < MapDepth; i++) begin
         used_bits[i] = 0; valid_bits[i] = 0;
      end
      length_m = 0; free_m = 0; cursor_m = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add(KIND_QUERY, 0, 0, 0);
      add(KIND_FREE, 4095, 1, 8191);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_WVALID, 1, 1, 0);
      add(KIND_QUERY, 1, 0, 0);
      add(KIND_FREE, 0, 0, 0);
      add(KIND_FREE, 0, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_WVALID, 2, 1, 0);
      add_raw({16'h1fff, 1'b1, 12'hfff, 3'd5});
      add_raw({16'h0, 1'b0, 12'd0, 3'd7});
      add_raw({16'h0, 1'b1, 12'd1, 3'd6});
      add(KIND_INIT, 4095, 1, 8191);
      add(KIND_QUERY, 4095, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_INIT, 0, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_INIT, 7, 0, 4096);
      for (int i = 0; i < 20; i++) add(KIND_ALLOC, 0, 0, 0);
      add(KIND_FREE, 5, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_INIT, 0, 0, 0);
      for (int i = 0; i < 290; i++) add(KIND_ALLOC, 0, 0, 0);
      add(KIND_FREE, 289, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_ALLOC, 0, 0, 0);
      add(KIND_QUERY, 289, 0, 0);

      wait (pending_reqs.size() == 0);
      hold_req = 1;
      for (int i = 0; i < 40; i++) add(KIND_QUERY, i, 0, 0);

      for (int i = 0; i < 620; i++) begin
         r = $urandom_range(0, 99);
         if (pending_reqs.size() > 50) wait (pending_reqs.size() < 20);
         if (i == 540) begin
            wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
            quiet = 1; send_gap = 0; recv_gap = 0;
         end
         if (r < 3) begin
            add(KIND_INIT, $urandom_range(0, 4095), $urandom_range(0, 1),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 40));
         end else if (r < 40) add(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 8191));
         else if (r < 60) add(KIND_FREE, $urandom_range(0, 50), $urandom_range(0, 1), 0);
         else if (r < 75) add(KIND_WVALID, $urandom_range(0, 50), $urandom_range(0, 1), 0);
         else if (r < 90) add(KIND_QUERY, $urandom_range(0, 50), $urandom_range(0, 1), 0);
         else if (r < 95) add_raw({3'b0, 13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                                   12'($urandom_range(0, 4095)), 3'($urandom_range(1, 3))});
         else add_raw({3'b0, 13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                       12'($urandom_range(0, 4095)), 3'($urandom_range(5, 7))});
      end
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
